@@ rtl/assert_macros.svh @@
// Assertion macros for the wake qualifier RTL (included by wsq_ctrl).
// Assertions are compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Concurrent check that is skipped while reset is asserted.
`define WSQ_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Concurrent check that also runs during reset.
`define WSQ_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`else

`define WSQ_ASSERT(label, clk, rst_n, prop)
`define WSQ_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

@@ rtl/wsq_pkg.sv @@
// Shared types and codes for the wake signal qualifier and shutdown control.
// No dependencies; the RTL modules and the testbench import this package.
`timescale 1ns / 1ps

package wsq_pkg;

    localparam int NUM_LINES = 4;

    // Qualified line state codes.
    localparam logic [1:0] LINE_INIT = 2'd0;
    localparam logic [1:0] LINE_OFF  = 2'd1;
    localparam logic [1:0] LINE_ON   = 2'd2;

    // Mode command codes.
    localparam logic [1:0] MODE_NONE     = 2'd0;
    localparam logic [1:0] MODE_SHUTDOWN = 2'd1;
    localparam logic [1:0] MODE_RESTORE  = 2'd2;

    // Power command codes.
    localparam logic [1:0] PWR_NONE = 2'd0;
    localparam logic [1:0] PWR_OFF  = 2'd1;
    localparam logic [1:0] PWR_ON   = 2'd2;

    // Configuration register indexes.
    localparam logic REG_OFF_THRESHOLD = 1'b0;
    localparam logic REG_SHUTDOWN_EN   = 1'b1;

    // Saturation limits of the counters.
    localparam logic [2:0]  QUAL_CNT_MAX   = 3'd7;
    localparam logic [7:0]  TICK8_MAX      = 8'd255;
    localparam logic [15:0] SAVE_TICKS_MAX = 16'd65500;

    typedef logic [1:0] t_line_state;

    typedef struct packed {
        logic [15:0] ignition_volt;
        logic [15:0] offboard_charge_volt;
        logic [15:0] onboard_charge_volt;
        logic [15:0] alarm_volt;
        logic        vehicle_shutdown_request;
        logic [3:0]  current_run_mode;
    } t_in_beat;

    typedef struct packed {
        logic        control_step_done;
        logic [7:0]  line_states;
        logic [1:0]  combined_state;
        logic        awake;
        logic [1:0]  mode_command;
        logic [3:0]  restore_mode;
        logic [1:0]  module_power_command;
        logic [1:0]  main_power_command;
        logic        shutdown_enable_flag;
        logic        poweroff_record_request;
        logic        periodic_time_save;
    } t_out_beat;

endpackage

@@ rtl/wsq_lane.sv @@
// One wake line qualifier lane: threshold compare and debounce counters.
// Depends on wsq_pkg.
`timescale 1ns / 1ps

module wsq_lane
    import wsq_pkg::*;
#(
    parameter int QUALIFY_COUNT = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic [15:0] i_volt,
    input  logic [15:0] i_off_threshold,
    output t_line_state o_state_next
);

    localparam logic [2:0] QUAL_LIMIT = 3'(QUALIFY_COUNT);

    logic [2:0]  r_on_cnt;
    logic [2:0]  n_on_cnt;
    logic [2:0]  r_off_cnt;
    logic [2:0]  n_off_cnt;
    t_line_state r_state;
    t_line_state n_state;
    logic        w_is_off;

    assign w_is_off = i_volt < i_off_threshold;

    // Count agreeing samples, then qualify; an off result wins.
    always_comb begin
        n_on_cnt  = r_on_cnt;
        n_off_cnt = r_off_cnt;
        n_state   = r_state;
        if (i_step) begin
            if (w_is_off) begin
                n_on_cnt  = 3'd0;
                n_off_cnt = (r_off_cnt < QUAL_CNT_MAX) ? r_off_cnt + 3'd1 : r_off_cnt;
            end else begin
                n_off_cnt = 3'd0;
                n_on_cnt  = (r_on_cnt < QUAL_CNT_MAX) ? r_on_cnt + 3'd1 : r_on_cnt;
            end
            if (n_off_cnt >= QUAL_LIMIT) begin
                n_off_cnt = QUAL_LIMIT;
                n_state   = LINE_OFF;
            end else if (n_on_cnt >= QUAL_LIMIT) begin
                n_on_cnt = QUAL_LIMIT;
                n_state  = LINE_ON;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on_cnt  <= 3'd0;
            r_off_cnt <= 3'd0;
            r_state   <= LINE_INIT;
        end else begin
            r_on_cnt  <= n_on_cnt;
            r_off_cnt <= n_off_cnt;
            r_state   <= n_state;
        end
    end

    assign o_state_next = n_state;

endmodule

@@ rtl/wsq_ctrl.sv @@
// Merge stage: combines the lane states and runs the shutdown sequencing,
// tick timers and periodic save. Depends on wsq_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wsq_ctrl
    import wsq_pkg::*;
#(
    parameter int CONTROL_PERIOD_TICKS  = 10,
    parameter int POWER_OFF_DELAY_TICKS = 100,
    parameter int SAVE_PERIOD_TICKS     = 30000
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic        i_shutdown_req,
    input  logic [3:0]  i_run_mode,
    input  logic        i_shutdown_en,
    input  t_line_state i_line_next [NUM_LINES],
    output logic        o_ctrl_tick,
    output t_out_beat   o_result
);

    localparam logic [7:0]  PERIOD_LIMIT = 8'(CONTROL_PERIOD_TICKS);
    localparam logic [7:0]  DELAY_LIMIT  = 8'(POWER_OFF_DELAY_TICKS);
    localparam logic [15:0] SAVE_LIMIT   = 16'(SAVE_PERIOD_TICKS);

    logic [7:0]  r_period;
    logic [7:0]  n_period;
    logic [7:0]  r_powerdown;
    logic [7:0]  n_powerdown;
    logic [15:0] r_save;
    logic [15:0] n_save;
    logic        r_mode_saved;
    logic        n_mode_saved;
    logic [3:0]  r_saved_mode;
    logic [3:0]  n_saved_mode;
    logic        r_record_done;
    logic        n_record_done;
    logic        r_shutdown_flag;
    logic        n_shutdown_flag;

    logic [7:0]  w_period_inc;
    logic [7:0]  w_powerdown_inc;
    logic [15:0] w_save_inc;
    logic        w_all_off;
    logic        w_any_on;
    t_line_state w_combined;
    logic [7:0]  w_lines;
    logic        w_go_down;
    t_out_beat   w_res;

    // Saturating tick counters, advanced once per accepted beat.
    assign w_period_inc    = (r_period < TICK8_MAX) ? r_period + 8'd1 : r_period;
    assign w_powerdown_inc = (r_powerdown < TICK8_MAX) ? r_powerdown + 8'd1 : r_powerdown;
    assign w_save_inc      = (r_save < SAVE_TICKS_MAX) ? r_save + 16'd1 : r_save;
    assign o_ctrl_tick     = w_period_inc >= PERIOD_LIMIT;

    // Combine the four lane states.
    always_comb begin
        w_all_off = 1'b1;
        w_any_on  = 1'b0;
        w_lines   = 8'd0;
        for (int k = 0; k < NUM_LINES; k++) begin
            if (i_line_next[k] != LINE_OFF) w_all_off = 1'b0;
            if (i_line_next[k] == LINE_ON) w_any_on = 1'b1;
            w_lines[2*k +: 2] = i_line_next[k];
        end
        if (w_all_off) begin
            w_combined = LINE_OFF;
        end else if (w_any_on) begin
            w_combined = LINE_ON;
        end else begin
            w_combined = LINE_INIT;
        end
    end

    assign w_go_down = (w_combined == LINE_OFF) || i_shutdown_req;

    // Shutdown and wake sequencing for one beat.
    always_comb begin
        n_period        = r_period;
        n_powerdown     = r_powerdown;
        n_save          = r_save;
        n_mode_saved    = r_mode_saved;
        n_saved_mode    = r_saved_mode;
        n_record_done   = r_record_done;
        n_shutdown_flag = r_shutdown_flag;

        w_res                         = '0;
        w_res.line_states             = w_lines;
        w_res.combined_state          = w_combined;
        w_res.mode_command            = MODE_NONE;
        w_res.module_power_command    = PWR_NONE;
        w_res.main_power_command      = PWR_NONE;

        if (i_step) begin
            n_period    = w_period_inc;
            n_powerdown = w_powerdown_inc;
            n_save      = w_save_inc;

            if (o_ctrl_tick) begin
                n_period                = 8'd0;
                w_res.control_step_done = 1'b1;
                if (w_go_down) begin
                    if (!r_mode_saved) begin
                        n_mode_saved = 1'b1;
                        n_saved_mode = i_run_mode;
                    end
                    w_res.mode_command = MODE_SHUTDOWN;
                    if (i_shutdown_en) begin
                        w_res.module_power_command = PWR_OFF;
                        n_shutdown_flag            = 1'b1;
                        if (w_powerdown_inc >= DELAY_LIMIT) begin
                            n_powerdown              = 8'd0;
                            w_res.main_power_command = PWR_OFF;
                        end
                    end else begin
                        n_powerdown     = 8'd0;
                        n_shutdown_flag = 1'b0;
                    end
                    if (!r_record_done) begin
                        w_res.poweroff_record_request = 1'b1;
                        n_record_done                 = 1'b1;
                    end
                end else begin
                    if (r_mode_saved) begin
                        n_mode_saved       = 1'b0;
                        w_res.mode_command = MODE_RESTORE;
                        w_res.restore_mode = r_saved_mode;
                    end
                    n_powerdown = 8'd0;
                    w_res.awake = 1'b1;
                    if (r_record_done) begin
                        w_res.module_power_command = PWR_ON;
                        w_res.main_power_command   = PWR_ON;
                        n_shutdown_flag            = 1'b0;
                        n_record_done              = 1'b0;
                    end
                end
            end

            // Periodic time save runs on its own timer.
            if (w_save_inc >= SAVE_LIMIT) begin
                n_save                   = 16'd0;
                w_res.periodic_time_save = 1'b1;
            end
        end
        w_res.shutdown_enable_flag = n_shutdown_flag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period        <= 8'd0;
            r_powerdown     <= 8'd0;
            r_save          <= 16'd0;
            r_mode_saved    <= 1'b0;
            r_saved_mode    <= 4'd0;
            r_record_done   <= 1'b0;
            r_shutdown_flag <= 1'b0;
        end else begin
            r_period        <= n_period;
            r_powerdown     <= n_powerdown;
            r_save          <= n_save;
            r_mode_saved    <= n_mode_saved;
            r_saved_mode    <= n_saved_mode;
            r_record_done   <= n_record_done;
            r_shutdown_flag <= n_shutdown_flag;
        end
    end

    assign o_result = w_res;

    // The period counter wraps before it reaches the control period.
    `WSQ_ASSERT(a_period_below_limit, i_clk, i_rst_n, r_period < PERIOD_LIMIT)
    // A record request only comes with a shutdown command.
    `WSQ_ASSERT(a_record_with_shutdown, i_clk, i_rst_n,
        w_res.poweroff_record_request |-> (w_res.mode_command == MODE_SHUTDOWN))
    // Main power is only cut while module power is being cut.
    `WSQ_ASSERT(a_main_off_needs_module_off, i_clk, i_rst_n,
        (w_res.main_power_command == PWR_OFF) |-> (w_res.module_power_command == PWR_OFF))
    // A record request is never issued twice without a wake in between.
    `WSQ_ASSERT(a_record_once, i_clk, i_rst_n,
        (i_step && w_res.poweroff_record_request) |=> r_record_done)

endmodule

@@ rtl/wake_signal_qualifier_shutdown_control_top.sv @@
// Top level of the wake signal qualifier and shutdown control block.
// Depends on wsq_pkg, wsq_lane and wsq_ctrl.
`timescale 1ns / 1ps

// Usage:
// Each input beat on i_in_data is one timer tick carrying four wake line
// voltages, a shutdown request and the present run mode. Every beat gives
// exactly one result beat on o_out_data.
// Four qualifier lanes compare and debounce the lines in parallel; a merge
// stage combines them and runs the shutdown, power and time-save logic.
// The result is held in an output register and shows on o_out_valid in the
// cycle after the input beat is accepted.
// Throughput is one beat per cycle while the receiver takes each result, set by
// the single output register that is refilled in the same cycle it is drained.
// When the receiver stalls, the held result stays on o_out_data and
// o_in_ready drops until that result is taken.
// Reset (synchronous, active low) clears all counters and line states, sets the
// off threshold to 0 and enables system shutdown. The two registers are written
// over the APB port at byte addresses 0 (off threshold) and 4 (shutdown enable);
// the user must write them only while the block is idle; the block does not enforce it.

module wake_signal_qualifier_shutdown_control_top
    import wsq_pkg::*;
#(
    parameter int QUALIFY_COUNT         = 5,
    parameter int CONTROL_PERIOD_TICKS  = 10,
    parameter int POWER_OFF_DELAY_TICKS = 100,
    parameter int SAVE_PERIOD_TICKS     = 30000
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_beat    i_in_data,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_beat   o_out_data,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] r_off_threshold;
    logic        r_shutdown_en;
    logic        r_out_valid;
    t_out_beat   r_out_data;

    logic        w_accept;
    logic        w_ctrl_tick;
    logic        w_lane_step;
    logic        w_cfg_write;
    logic [15:0] w_volt [NUM_LINES];
    t_line_state w_line_next [NUM_LINES];
    t_out_beat   w_result;

    // Configuration registers.
    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_threshold <= 16'd0;
            r_shutdown_en   <= 1'b1;
        end else if (w_cfg_write) begin
            case (paddr[2])
                REG_OFF_THRESHOLD: r_off_threshold <= pwdata[15:0];
                REG_SHUTDOWN_EN:   r_shutdown_en   <= pwdata[0];
                default:           r_shutdown_en   <= r_shutdown_en;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_OFF_THRESHOLD: prdata = {16'd0, r_off_threshold};
            REG_SHUTDOWN_EN:   prdata = {31'd0, r_shutdown_en};
            default:           prdata = 32'd0;
        endcase
    end

    // Input handshake: a new beat enters whenever the output slot frees up.
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_lane_step = w_accept && w_ctrl_tick;

    assign w_volt[0] = i_in_data.ignition_volt;
    assign w_volt[1] = i_in_data.offboard_charge_volt;
    assign w_volt[2] = i_in_data.onboard_charge_volt;
    assign w_volt[3] = i_in_data.alarm_volt;

    // Qualifier lanes, one per wake line.
    for (genvar g = 0; g < NUM_LINES; g++) begin : g_lane
        wsq_lane #(
            .QUALIFY_COUNT (QUALIFY_COUNT)
        ) u_lane (
            .i_clk           (i_clk),
            .i_rst_n         (i_rst_n),
            .i_step          (w_lane_step),
            .i_volt          (w_volt[g]),
            .i_off_threshold (r_off_threshold),
            .o_state_next    (w_line_next[g])
        );
    end

    // Merge stage and shutdown sequencing.
    wsq_ctrl #(
        .CONTROL_PERIOD_TICKS  (CONTROL_PERIOD_TICKS),
        .POWER_OFF_DELAY_TICKS (POWER_OFF_DELAY_TICKS),
        .SAVE_PERIOD_TICKS     (SAVE_PERIOD_TICKS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (w_accept),
        .i_shutdown_req (i_in_data.vehicle_shutdown_request),
        .i_run_mode     (i_in_data.current_run_mode),
        .i_shutdown_en  (r_shutdown_en),
        .i_line_next    (w_line_next),
        .o_ctrl_tick    (w_ctrl_tick),
        .o_result       (w_result)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

@@ tb/tb_wake_signal_qualifier_shutdown_control_top.sv @@
// Self-checking testbench for the wake signal qualifier and shutdown control block.
// Depends on wsq_pkg and wake_signal_qualifier_shutdown_control_top; a scoreboard
// class predicts every result beat and checks it against the block.
`timescale 1ns / 1ps

module tb_wake_signal_qualifier_shutdown_control_top;
    import wsq_pkg::*;

    localparam int QUALIFY_COUNT         = 5;
    localparam int CONTROL_PERIOD_TICKS  = 10;
    localparam int POWER_OFF_DELAY_TICKS = 100;
    localparam int SAVE_PERIOD_TICKS     = 30000;

    // Register byte addresses follow the register indexes, four bytes apart.
    localparam logic [2:0] ADDR_OFF_THRESHOLD = {REG_OFF_THRESHOLD, 2'b00};
    localparam logic [2:0] ADDR_SHUTDOWN_EN   = {REG_SHUTDOWN_EN, 2'b00};

    localparam int PHASE_TICKS     = 80;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int CYCLE_LIMIT     = 250000;

    // Predicts the result beat of every tick and checks the block's results in order.
    class wake_tick_scoreboard;
        t_out_beat   pending_results[$];
        logic [15:0] off_thr;
        logic        shut_en;
        logic [2:0]  on_cnt [NUM_LINES];
        logic [2:0]  off_cnt [NUM_LINES];
        t_line_state lstate [NUM_LINES];
        logic [7:0]  period_cnt;
        logic [7:0]  pdown_cnt;
        logic [15:0] save_cnt;
        logic        mode_held;
        logic [3:0]  held_mode;
        logic        rec_sent;
        logic        shut_flag;
        int          fail_count;

        function new();
            off_thr    = '0;
            shut_en    = 1'b1;
            period_cnt = '0;
            pdown_cnt  = '0;
            save_cnt   = '0;
            mode_held  = 1'b0;
            held_mode  = '0;
            rec_sent   = 1'b0;
            shut_flag  = 1'b0;
            fail_count = 0;
            for (int k = 0; k < NUM_LINES; k++) begin
                on_cnt[k]  = '0;
                off_cnt[k] = '0;
                lstate[k]  = LINE_INIT;
            end
        endfunction

        task report_mismatch(input string what);
            $display("mismatch at %0t: %s", $realtime, what);
            fail_count++;
        endtask

        // Debounce one line sample; an off qualification wins over an on one.
        function void qualify_line(input int k, input logic [15:0] volt);
            if (volt < off_thr) begin
                if (off_cnt[k] < QUAL_CNT_MAX) off_cnt[k]++;
                on_cnt[k] = '0;
            end else begin
                off_cnt[k] = '0;
                if (on_cnt[k] < QUAL_CNT_MAX) on_cnt[k]++;
            end
            if (off_cnt[k] >= QUALIFY_COUNT) begin
                off_cnt[k] = 3'(QUALIFY_COUNT);
                lstate[k]  = LINE_OFF;
            end else if (on_cnt[k] >= QUALIFY_COUNT) begin
                on_cnt[k] = 3'(QUALIFY_COUNT);
                lstate[k] = LINE_ON;
            end
        endfunction

        function t_line_state combined();
            logic all_off;
            logic any_on;
            all_off = 1'b1;
            any_on  = 1'b0;
            for (int k = 0; k < NUM_LINES; k++) begin
                if (lstate[k] != LINE_OFF) all_off = 1'b0;
                if (lstate[k] == LINE_ON) any_on = 1'b1;
            end
            if (all_off) return LINE_OFF;
            if (any_on) return LINE_ON;
            return LINE_INIT;
        endfunction

        // Advance the model by one accepted tick and queue the result it gives.
        function void note_tick(input t_in_beat b);
            t_out_beat   r;
            logic [15:0] volts [NUM_LINES];
            r = '0;
            volts[0] = b.ignition_volt;
            volts[1] = b.offboard_charge_volt;
            volts[2] = b.onboard_charge_volt;
            volts[3] = b.alarm_volt;

            if (period_cnt < TICK8_MAX) period_cnt++;
            if (pdown_cnt < TICK8_MAX) pdown_cnt++;
            if (save_cnt < SAVE_TICKS_MAX) save_cnt++;

            // Control evaluation once per period.
            if (period_cnt >= CONTROL_PERIOD_TICKS) begin
                period_cnt = '0;
                r.control_step_done = 1'b1;
                for (int k = 0; k < NUM_LINES; k++) qualify_line(k, volts[k]);
                if (combined() == LINE_OFF || b.vehicle_shutdown_request) begin
                    if (!mode_held) begin
                        mode_held = 1'b1;
                        held_mode = b.current_run_mode;
                    end
                    r.mode_command = MODE_SHUTDOWN;
                    if (shut_en) begin
                        r.module_power_command = PWR_OFF;
                        shut_flag = 1'b1;
                        if (pdown_cnt >= POWER_OFF_DELAY_TICKS) begin
                            pdown_cnt = '0;
                            r.main_power_command = PWR_OFF;
                        end
                    end else begin
                        pdown_cnt = '0;
                        shut_flag = 1'b0;
                    end
                    if (!rec_sent) begin
                        r.poweroff_record_request = 1'b1;
                        rec_sent = 1'b1;
                    end
                end else begin
                    if (mode_held) begin
                        mode_held      = 1'b0;
                        r.mode_command = MODE_RESTORE;
                        r.restore_mode = held_mode;
                    end
                    pdown_cnt = '0;
                    r.awake   = 1'b1;
                    if (rec_sent) begin
                        r.module_power_command = PWR_ON;
                        r.main_power_command   = PWR_ON;
                        shut_flag = 1'b0;
                        rec_sent  = 1'b0;
                    end
                end
            end

            // The time save runs on its own period.
            if (save_cnt >= SAVE_PERIOD_TICKS) begin
                save_cnt = '0;
                r.periodic_time_save = 1'b1;
            end

            r.line_states          = {lstate[3], lstate[2], lstate[1], lstate[0]};
            r.combined_state       = combined();
            r.shutdown_enable_flag = shut_flag;
            pending_results.push_back(r);
        endfunction

        task compare_field(input string name, input int unsigned got, input int unsigned want);
            if (got != want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
        endtask

        task check_result(input t_out_beat got);
            t_out_beat want;
            if (pending_results.size() == 0) begin
                report_mismatch("result beat with no prediction waiting");
            end else begin
                want = pending_results.pop_front();
                compare_field("control_step_done", got.control_step_done, want.control_step_done);
                compare_field("line_states", got.line_states, want.line_states);
                compare_field("combined_state", got.combined_state, want.combined_state);
                compare_field("awake", got.awake, want.awake);
                compare_field("mode_command", got.mode_command, want.mode_command);
                compare_field("restore_mode", got.restore_mode, want.restore_mode);
                compare_field("module_power_command", got.module_power_command,
                              want.module_power_command);
                compare_field("main_power_command", got.main_power_command,
                              want.main_power_command);
                compare_field("shutdown_enable_flag", got.shutdown_enable_flag,
                              want.shutdown_enable_flag);
                compare_field("poweroff_record_request", got.poweroff_record_request,
                              want.poweroff_record_request);
                compare_field("periodic_time_save", got.periodic_time_save,
                              want.periodic_time_save);
            end
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_beat    i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_beat   o_out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    wake_tick_scoreboard sb;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int hold_req_seq = 0;
    int hold_seen    = 0;
    int hold_left    = 0;
    int cycle_count  = 0;
    logic line_low [NUM_LINES] = '{1'b0, 1'b0, 1'b0, 1'b0};
    logic req_hold = 1'b0;

    wake_signal_qualifier_shutdown_control_top #(
        .QUALIFY_COUNT        (QUALIFY_COUNT),
        .CONTROL_PERIOD_TICKS (CONTROL_PERIOD_TICKS),
        .POWER_OFF_DELAY_TICKS(POWER_OFF_DELAY_TICKS),
        .SAVE_PERIOD_TICKS    (SAVE_PERIOD_TICKS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // Clock with a 2 ns period.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_wake_signal_qualifier_shutdown_control_top failed");
            $finish;
        end
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (hold_req_seq != hold_seen) begin
            hold_seen = hold_req_seq;
            hold_left = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Beat monitor: check the result first, then predict from the accepted tick.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) sb.check_result(o_out_data);
            if (i_in_valid && o_in_ready) sb.note_tick(i_in_data);
        end
    end

    // Voltage on the requested side of the present off threshold (at or above it when the threshold is zero).
    function automatic logic [15:0] pick_volt(input logic low);
        if (low && sb.off_thr != 16'd0) return 16'($urandom_range(sb.off_thr - 1, 0));
        return 16'($urandom_range(65535, sb.off_thr));
    endfunction

    // Mostly steady line patterns so lines qualify, with some noise samples.
    function automatic t_in_beat make_tick();
        t_in_beat    b;
        logic [15:0] v [NUM_LINES];
        int          scenario;
        if ($urandom_range(59) == 0) begin
            scenario = $urandom_range(2);
            for (int k = 0; k < NUM_LINES; k++) begin
                line_low[k] = (scenario == 0) ? 1'b1 :
                              (scenario == 1) ? 1'b0 : 1'($urandom_range(1));
            end
        end
        if ($urandom_range(119) == 0) req_hold = ~req_hold;
        for (int k = 0; k < NUM_LINES; k++) begin
            v[k] = ($urandom_range(9) == 0) ? 16'($urandom) : pick_volt(line_low[k]);
        end
        b.ignition_volt            = v[0];
        b.offboard_charge_volt     = v[1];
        b.onboard_charge_volt      = v[2];
        b.alarm_volt               = v[3];
        b.vehicle_shutdown_request = req_hold ^ ($urandom_range(24) == 0);
        b.current_run_mode         = 4'($urandom);
        return b;
    endfunction

    // One APB transfer: setup cycle, then access until pready.
    task apb_transfer(input logic wr, input logic [2:0] addr, input logic [31:0] data,
                      output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Write both registers, read them back and update the model.
    task set_config(input logic [15:0] thr, input logic en);
        logic [31:0] rdata;
        apb_transfer(1'b1, ADDR_OFF_THRESHOLD, {16'd0, thr}, rdata);
        apb_transfer(1'b1, ADDR_SHUTDOWN_EN, {31'd0, en}, rdata);
        sb.off_thr = thr;
        sb.shut_en = en;
        @(posedge i_clk);
        apb_transfer(1'b0, ADDR_OFF_THRESHOLD, '0, rdata);
        if (rdata != {16'd0, thr})
            sb.report_mismatch($sformatf("off threshold read %0h expected %0h", rdata, thr));
        apb_transfer(1'b0, ADDR_SHUTDOWN_EN, '0, rdata);
        if (rdata != {31'd0, en})
            sb.report_mismatch($sformatf("shutdown enable read %0h expected %0h", rdata, en));
        @(posedge i_clk);
    endtask

    // Offer one tick beat after a random gap and hold it until accepted.
    task send_tick(input t_in_beat b);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Stop sending and wait until every predicted result has been taken.
    task wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_results.size() != 0) @(posedge i_clk);
    endtask

    task run_phase(input logic [15:0] thr, input logic en, input int tx, input int rx,
                   input int n, input logic hold);
        wait_drained();
        set_config(thr, en);
        tx_idle_pct  = tx;
        rx_stall_pct = rx;
        if (hold) hold_req_seq++;
        repeat (n) send_tick(make_tick());
    endtask

    initial begin
        t_in_beat b;
        sb = new();
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: all lines at zero, then all at full scale with a shutdown
        // request and the top run mode, then mixed extremes.
        set_config(16'h4000, 1'b1);
        for (int n = 0; n < 24; n++) begin
            if (n < 10) begin
                b = '0;
            end else if (n < 20) begin
                b = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 4'hF};
            end else begin
                b.ignition_volt            = n[0] ? 16'hFFFF : 16'h0000;
                b.offboard_charge_volt     = n[0] ? 16'h0000 : 16'hFFFF;
                b.onboard_charge_volt      = n[1] ? 16'hFFFF : 16'h0000;
                b.alarm_volt               = n[1] ? 16'h0000 : 16'hFFFF;
                b.vehicle_shutdown_request = n[0];
                b.current_run_mode         = 4'(n);
            end
            send_tick(b);
        end

        // Random phases over thresholds, shutdown enable, sender idling and receiver stalls.
        run_phase(16'h8000, 1'b1, 0, 0, PHASE_TICKS, 1'b0);
        run_phase(16'h0000, 1'b1, 56, 0, PHASE_TICKS, 1'b0);
        run_phase(16'hFFFF, 1'b0, 0, 56, PHASE_TICKS, 1'b0);
        run_phase(16'($urandom_range(65534, 1)), 1'b1, 34, 34, PHASE_TICKS, 1'b1);
        run_phase(16'($urandom_range(65534, 1)), 1'b0, 34, 34, PHASE_TICKS, 1'b0);

        wait_drained();
        repeat (4) @(posedge i_clk);
        if (sb.pending_results.size() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived",
                                         sb.pending_results.size()));
        if (sb.fail_count == 0) begin
            $display("tb_wake_signal_qualifier_shutdown_control_top passed");
        end else begin
            $display("tb_wake_signal_qualifier_shutdown_control_top failed");
        end
        $finish;
    end

endmodule
